// ----- rtl/mhpq_pkg.sv -----
// shared constants and types of the max-heap priority queue
`timescale 1ns / 1ps

package mhpq_pkg;

    localparam int DEPTH   = 1024;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int CH_W    = ADDR_W + 2;
    localparam int KEY_W   = 32;
    localparam int ENTRY_W = 11;

    typedef logic signed [KEY_W-1:0] key_t;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_POP_EMPTY = 2'd1,
        STATUS_INS_FULL  = 2'd2
    } status_t;

    typedef enum logic {
        MODE_INSERT = 1'b0,
        MODE_POP    = 1'b1
    } mode_t;

    // outcome of one sift-down compare
    typedef struct packed {
        logic move;
        logic right;
        key_t key;
    } pick_t;

endpackage

// ----- rtl/mhpq_pick.sv -----
// child selection compare for one sift-down level
`timescale 1ns / 1ps

module mhpq_pick
    import mhpq_pkg::*;
(
    input  key_t  key,
    input  key_t  left_key,
    input  key_t  right_key,
    input  logic  has_right,
    output pick_t pick
);

    logic left_gt;
    logic right_gt;
    key_t best;

    always_comb
    begin
        left_gt    = left_key > key;
        best       = left_gt ? left_key : key;
        right_gt   = has_right && (right_key > best);
        pick.move  = left_gt || right_gt;
        pick.right = right_gt;
        pick.key   = right_gt ? right_key : left_key;
    end

endmodule

// ----- rtl/max_heap_priority_queue_core.sv -----
// max-heap priority queue top level with sift-down compare unit and heap memory
//
//  channel  | signals                                   | dir | transaction
//  ---------+-------------------------------------------+-----+---------------------------
//  request  | in_valid in_ready mode key_in             | in  | insert or pop one key
//  response | out_valid out_ready popped_key top_key    | out | one per request
//           | top_valid entry_count status              |     |
//
// insert: each level climbed reads the parent, then compares and writes
// pop: each level descended reads left child, then right child, then compares and writes
// the heap memory has a single read port, so each child read has its own state; errors and
// a pop of the last key go straight to the response
// in_ready is high only while no request is in progress
// a held response stalls the sequencer, not the heap contents
// reset empties the heap at once; memory contents need no clearing
`timescale 1ns / 1ps

module max_heap_priority_queue_core
    import mhpq_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                mode,
    input  logic signed [31:0]  key_in,
    output logic                out_valid,
    input  logic                out_ready,
    output logic signed [31:0]  popped_key,
    output logic signed [31:0]  top_key,
    output logic                top_valid,
    output logic [ENTRY_W-1:0]  entry_count,
    output logic [1:0]          status
);

    typedef enum logic [8:0] {
        ST_IDLE     = 9'b000000001,
        ST_UP_RD    = 9'b000000010,
        ST_UP_CMP   = 9'b000000100,
        ST_LAST_RD  = 9'b000001000,
        ST_LAST_GET = 9'b000010000,
        ST_DN_L     = 9'b000100000,
        ST_DN_R     = 9'b001000000,
        ST_DN_CMP   = 9'b010000000,
        ST_RESP     = 9'b100000000
    } state_t;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [ADDR_W-1:0]  pos_reg, pos_next;
    key_t               key_reg, key_next;
    key_t               left_reg, left_next;
    logic               has_r_reg, has_r_next;
    key_t               top_reg;
    key_t               popped_reg, popped_next;
    status_t            stat_reg, stat_next;

    logic               out_valid_reg;
    key_t               out_popped_reg;
    key_t               out_top_reg;
    logic               out_top_valid_reg;
    logic [ENTRY_W-1:0] out_count_reg;
    status_t            out_status_reg;

    key_t               heap_mem [DEPTH];
    key_t               rd_data_reg;
    logic               rd_en;
    logic [ADDR_W-1:0]  rd_addr;
    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;
    key_t               wr_data;

    logic [ADDR_W-1:0]  parent;
    logic [CH_W-1:0]    left_idx;
    logic [CH_W-1:0]    right_idx;
    logic [CH_W-1:0]    count_ext;
    logic               out_free;
    pick_t              pick;

    assign parent    = (pos_reg - ADDR_W'(1)) >> 1;
    assign left_idx  = {1'b0, pos_reg, 1'b1};
    assign right_idx = left_idx + CH_W'(1);
    assign count_ext = CH_W'(count_reg);
    assign out_free  = !out_valid_reg || out_ready;

    mhpq_pick u_pick
    (
        .key       (key_reg),
        .left_key  (left_reg),
        .right_key (rd_data_reg),
        .has_right (has_r_reg),
        .pick      (pick)
    );

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        pos_next    = pos_reg;
        key_next    = key_reg;
        left_next   = left_reg;
        has_r_next  = has_r_reg;
        popped_next = popped_reg;
        stat_next   = stat_reg;
        rd_en       = 1'b0;
        rd_addr     = parent;
        wr_en       = 1'b0;
        wr_addr     = pos_reg;
        wr_data     = key_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    popped_next = '0;
                    stat_next   = STATUS_OK;
                    if (mode == MODE_INSERT)
                    begin
                        if (count_reg >= CNT_W'(DEPTH))
                        begin
                            stat_next  = STATUS_INS_FULL;
                            state_next = ST_RESP;
                        end
                        else
                        begin
                            key_next   = key_in;
                            pos_next   = ADDR_W'(count_reg);
                            count_next = count_reg + CNT_W'(1);
                            state_next = ST_UP_RD;
                        end
                    end
                    else
                    begin
                        if (count_reg == '0)
                        begin
                            stat_next  = STATUS_POP_EMPTY;
                            state_next = ST_RESP;
                        end
                        else
                        begin
                            popped_next = top_reg;
                            count_next  = count_reg - CNT_W'(1);
                            state_next  = (count_reg == CNT_W'(1)) ? ST_RESP : ST_LAST_RD;
                        end
                    end
                end
            end
            ST_UP_RD:
            begin
                if (pos_reg == '0)
                begin
                    wr_en      = 1'b1;
                    state_next = ST_RESP;
                end
                else
                begin
                    rd_en      = 1'b1;
                    state_next = ST_UP_CMP;
                end
            end
            ST_UP_CMP:
            begin
                wr_en = 1'b1;
                if (key_reg > rd_data_reg)
                begin
                    wr_data    = rd_data_reg;
                    pos_next   = parent;
                    state_next = ST_UP_RD;
                end
                else
                begin
                    state_next = ST_RESP;
                end
            end
            ST_LAST_RD:
            begin
                rd_en      = 1'b1;
                rd_addr    = ADDR_W'(count_reg);
                state_next = ST_LAST_GET;
            end
            ST_LAST_GET:
            begin
                key_next   = rd_data_reg;
                pos_next   = '0;
                state_next = ST_DN_L;
            end
            ST_DN_L:
            begin
                if (left_idx < count_ext)
                begin
                    rd_en      = 1'b1;
                    rd_addr    = left_idx[ADDR_W-1:0];
                    state_next = ST_DN_R;
                end
                else
                begin
                    wr_en      = 1'b1;
                    state_next = ST_RESP;
                end
            end
            ST_DN_R:
            begin
                left_next  = rd_data_reg;
                has_r_next = right_idx < count_ext;
                rd_en      = right_idx < count_ext;
                rd_addr    = right_idx[ADDR_W-1:0];
                state_next = ST_DN_CMP;
            end
            ST_DN_CMP:
            begin
                wr_en = 1'b1;
                if (pick.move)
                begin
                    wr_data    = pick.key;
                    pos_next   = pick.right ? right_idx[ADDR_W-1:0] : left_idx[ADDR_W-1:0];
                    state_next = ST_DN_L;
                end
                else
                begin
                    state_next = ST_RESP;
                end
            end
            ST_RESP:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // heap memory, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            heap_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= heap_mem[rd_addr];
        end
    end

    // root copy kept beside the memory
    always_ff @(posedge clk)
    begin
        if (wr_en && (wr_addr == '0))
        begin
            top_reg <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg    <= key_next;
        left_reg   <= left_next;
        has_r_reg  <= has_r_next;
        pos_reg    <= pos_next;
        popped_reg <= popped_next;
        stat_reg   <= stat_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (state_reg == ST_RESP && out_free)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_RESP && out_free)
        begin
            out_popped_reg    <= popped_reg;
            out_top_reg       <= (count_reg != '0) ? top_reg : '0;
            out_top_valid_reg <= count_reg != '0;
            out_count_reg     <= ENTRY_W'(count_reg);
            out_status_reg    <= stat_reg;
        end
    end

    assign in_ready    = state_reg == ST_IDLE;
    assign out_valid   = out_valid_reg;
    assign popped_key  = out_popped_reg;
    assign top_key     = out_top_reg;
    assign top_valid   = out_top_valid_reg;
    assign entry_count = out_count_reg;
    assign status      = out_status_reg;

endmodule

// ----- rtl/mhpq_checker.sv -----
// port-level checks for the max-heap priority queue, bound to the top level
`timescale 1ns / 1ps

module mhpq_checker
    import mhpq_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input logic                out_valid,
    input logic                out_ready,
    input logic signed [31:0]  popped_key,
    input logic signed [31:0]  top_key,
    input logic                top_valid,
    input logic [ENTRY_W-1:0]  entry_count,
    input logic [1:0]          status
);

    // one request in flight at a time
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("request taken while another is in progress");

    a_top_valid_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (top_valid == (entry_count != '0)))
        else $error("top_valid disagrees with entry_count");

    a_empty_pop: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == STATUS_POP_EMPTY) |-> (popped_key == '0 && !top_valid))
        else $error("pop on empty heap reported a key");

    a_empty_top: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !top_valid) |-> (top_key == '0))
        else $error("empty heap shows a nonzero top key");

    a_resp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(popped_key) && $stable(status)))
        else $error("stalled response changed");

endmodule

bind max_heap_priority_queue_core mhpq_checker u_mhpq_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .popped_key  (popped_key),
    .top_key     (top_key),
    .top_valid   (top_valid),
    .entry_count (entry_count),
    .status      (status)
);
